[sv/priority_deque_unit_defines.svh]
`ifndef PRIORITY_DEQUE_UNIT_DEFINES_SVH
`define PRIORITY_DEQUE_UNIT_DEFINES_SVH

// concurrent checks, compiled out when NO_ASSERTIONS is set
`ifndef NO_ASSERTIONS
`define PDQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("priority deque check failed");
`define PDQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("priority deque check failed");
`else
`define PDQ_ASSERT(lbl, clk, rst_n, prop)
`define PDQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[sv/pdq_pkg.sv]
`default_nettype none

package pdq_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // operation kinds
  localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PRIO_INS   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_PRIO_DEL   = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // what the cell row does in the update cycle
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_REM
  } op_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  priority_req;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] removed_value;
    logic signed [PRIO_W-1:0]  removed_priority;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] rear_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      empty_flag;
  } res_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic                     load_flag;
    logic [KIND_W-1:0]        kind;
    logic signed [PRIO_W-1:0] key;
    logic                     exec;
    op_e                      op;
    entry_t                   new_entry;
  } cell_ctl_t;

endpackage

`default_nettype wire

[sv/pdq_cell.sv]
`default_nettype none

module pdq_cell #(
  parameter int unsigned DEPTH = pdq_pkg::DEPTH_DEF,
  parameter int unsigned IDX   = 0
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pdq_pkg::cell_ctl_t                ctl_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]        count_i,
  input  wire pdq_pkg::entry_t                   left_i,
  input  wire pdq_pkg::entry_t                   right_i,
  output pdq_pkg::entry_t                        entry_o,
  input  wire logic                              hit_i,
  output logic                                   hit_o,
  input  wire pdq_pkg::entry_t                   rm_i,
  output pdq_pkg::entry_t                        rm_o,
  input  wire logic [pdq_pkg::VALUE_W-1:0]       rear_i,
  output logic [pdq_pkg::VALUE_W-1:0]            rear_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  pdq_pkg::entry_t entry_q, entry_d;
  logic flag_q, flag_d;
  logic occ, is_last, pri_gt, pri_eq, first;

  // position of this cell against the fill level
  assign occ     = (CW'(IDX) < count_i);
  assign is_last = (CW'(IDX + 1) == count_i);
  assign pri_gt  = ($signed(entry_q.prio) > $signed(ctl_i.key));
  assign pri_eq  = (entry_q.prio == ctl_i.key);

  // flag: insert here or further on, or removal candidate
  always_comb begin
    unique case (ctl_i.kind)
      pdq_pkg::KIND_PUSH_REAR:  flag_d = ~occ;
      pdq_pkg::KIND_PUSH_FRONT: flag_d = 1'b1;
      pdq_pkg::KIND_PRIO_INS:   flag_d = ~(occ & pri_gt);
      pdq_pkg::KIND_POP_FRONT:  flag_d = (IDX == 0);
      pdq_pkg::KIND_POP_REAR:   flag_d = is_last;
      pdq_pkg::KIND_PRIO_DEL:   flag_d = occ & pri_eq;
      default:                  flag_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (ctl_i.load_flag) begin
      flag_q <= flag_d;
    end
  end

  // first flagged cell along the row
  assign hit_o = hit_i | flag_q;
  assign first = flag_q & ~hit_i;

  // shift toward rear on insert, toward front on removal
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.exec) begin
      unique case (ctl_i.op)
        pdq_pkg::OP_INS: begin
          if (hit_o) begin
            entry_d = hit_i ? left_i : ctl_i.new_entry;
          end
        end
        pdq_pkg::OP_REM: begin
          if (hit_o) begin
            entry_d = right_i;
          end
        end
        default: entry_d = entry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

  // gather the removed word and the rear value along the row
  assign rm_o   = rm_i | ((first && ctl_i.op == pdq_pkg::OP_REM) ? entry_q : '0);
  assign rear_o = rear_i | (is_last ? entry_q.value : '0);

endmodule

`default_nettype wire

[sv/priority_deque_unit.sv]
// channel  dir  handshake               word
// in       in   in_valid_i/in_stall_o    in_item_i  (pdq_pkg::item_t)
// out      out  out_valid_o/out_stall_i  out_res_o  (pdq_pkg::res_t)
//
// one word at a time, the next only after its update: compare cycle at accept,
// then a row update cycle set by the insert/match ripple across the DEPTH cells
// rear/front are gathered from the row once the update result is registered and
// the output is free, which can overlap the compare cycle of the next word
// reset empties the row (count zero); no clearing pass
// a stalled output holds the next result back and then stalls the input
`default_nettype none

`include "priority_deque_unit_defines.svh"

module priority_deque_unit #(
  parameter int unsigned DEPTH = pdq_pkg::DEPTH_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire pdq_pkg::item_t  in_item_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output pdq_pkg::res_t        out_res_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic pend_q, pend_d, res_q, res_d, out_valid_q, out_valid_d;
  logic in_accept, gather, exec, found;
  logic [CW-1:0] count_q, count_d;
  pdq_pkg::item_t item_q;
  pdq_pkg::op_e op_q, op_d;
  logic [pdq_pkg::STATUS_W-1:0] st_q, st_d, res_st_q;
  pdq_pkg::entry_t res_rm_q;
  pdq_pkg::res_t out_q;
  pdq_pkg::cell_ctl_t ctl;

  pdq_pkg::entry_t entries [DEPTH];
  logic hit [DEPTH+1];
  pdq_pkg::entry_t rm [DEPTH+1];
  logic [pdq_pkg::VALUE_W-1:0] rear [DEPTH+1];

  // handshake and stage control
  assign in_accept = in_valid_i & ~pend_q;
  assign in_stall_o = pend_q;
  assign gather = res_q & (~out_valid_q | ~out_stall_i);
  assign exec = pend_q & (~res_q | gather);

  assign pend_d = in_accept | (pend_q & ~exec);
  assign res_d = exec | (res_q & ~gather);
  assign out_valid_d = gather | (out_valid_q & out_stall_i);

  // decode kind against the fill level
  always_comb begin
    op_d = pdq_pkg::OP_NONE;
    st_d = pdq_pkg::ST_OK;
    unique case (in_item_i.kind)
      pdq_pkg::KIND_PUSH_REAR, pdq_pkg::KIND_PUSH_FRONT, pdq_pkg::KIND_PRIO_INS: begin
        if (count_q == CW'(DEPTH)) begin
          st_d = pdq_pkg::ST_FULL;
        end else begin
          op_d = pdq_pkg::OP_INS;
        end
      end
      pdq_pkg::KIND_POP_FRONT, pdq_pkg::KIND_POP_REAR, pdq_pkg::KIND_PRIO_DEL: begin
        if (count_q == '0) begin
          st_d = pdq_pkg::ST_EMPTY;
        end else begin
          op_d = pdq_pkg::OP_REM;
        end
      end
      default: begin
        op_d = pdq_pkg::OP_NONE;
        st_d = pdq_pkg::ST_OK;
      end
    endcase
  end

  // fill level after the update
  always_comb begin
    count_d = count_q;
    if (exec && op_q == pdq_pkg::OP_INS) begin
      count_d = count_q + CW'(1);
    end else if (exec && op_q == pdq_pkg::OP_REM && found) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      op_q        <= pdq_pkg::OP_NONE;
    end else begin
      pend_q      <= pend_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      if (in_accept) begin
        op_q <= op_d;
      end
    end
  end

  // word, status and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item_i;
      st_q   <= st_d;
    end
    if (exec) begin
      res_st_q <= (op_q == pdq_pkg::OP_REM && !found) ? pdq_pkg::ST_NOTFOUND : st_q;
      res_rm_q <= rm[DEPTH];
    end
    if (gather) begin
      out_q.status           <= res_st_q;
      out_q.removed_value    <= res_rm_q.value;
      out_q.removed_priority <= res_rm_q.prio;
      out_q.front_value      <= (count_q != '0) ? entries[0].value : '0;
      out_q.rear_value       <= rear[DEPTH];
      out_q.entry_count      <= pdq_pkg::COUNT_W'(count_q);
      out_q.empty_flag       <= (count_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o = out_q;

  // broadcast to the row
  assign ctl.load_flag = in_accept;
  assign ctl.kind = in_item_i.kind;
  assign ctl.key = in_item_i.priority_req;
  assign ctl.exec = exec;
  assign ctl.op = op_q;
  assign ctl.new_entry.value = item_q.value;
  assign ctl.new_entry.prio = item_q.priority_req;

  assign hit[0] = 1'b0;
  assign rm[0] = '0;
  assign rear[0] = '0;
  assign found = hit[DEPTH];

  // row of cells, front at index zero
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pdq_pkg::entry_t left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entries[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entries[g+1];
    end

    pdq_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .count_i (count_q),
      .left_i  (left),
      .right_i (right),
      .entry_o (entries[g]),
      .hit_i   (hit[g]),
      .hit_o   (hit[g+1]),
      .rm_i    (rm[g]),
      .rm_o    (rm[g+1]),
      .rear_i  (rear[g]),
      .rear_o  (rear[g+1])
    );
  end

  // checks
  `PDQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `PDQ_ASSERT(a_ins_slot, clk_i, rst_ni, (exec && op_q == pdq_pkg::OP_INS) |-> found)
  `PDQ_ASSERT(a_ins_count, clk_i, rst_ni, (exec && op_q == pdq_pkg::OP_INS) |=> (count_q == $past(count_q) + CW'(1)))
  `PDQ_ASSERT(a_rem_count, clk_i, rst_ni, (exec && op_q == pdq_pkg::OP_REM && found) |=> (count_q == $past(count_q) - CW'(1)))

endmodule

`default_nettype wire

[tb/priority_deque_checker.sv]
`timescale 1ns / 100ps

module priority_deque_checker
  import pdq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  in_stall_i,
  input  wire item_t in_item_i,
  input  wire logic  out_valid_i,
  input  wire logic  out_stall_i,
  input  wire res_t  out_res_i,
  output int         err_cnt_o,
  output int         pending_o
);

  // shadow copy of the entry row, front at index 0
  logic signed [VALUE_W-1:0] row_value [DEPTH_DEF];
  logic signed [PRIO_W-1:0]  row_prio  [DEPTH_DEF];
  int unsigned               row_fill;

  res_t result_q [$];
  int   errors;

  initial begin
    errors    = 0;
    row_fill  = 0;
  end

  // open a slot at pos, shifting later entries toward the rear
  function automatic void insert_at(int unsigned pos, logic signed [VALUE_W-1:0] v,
                                    logic signed [PRIO_W-1:0] p);
    for (int unsigned i = row_fill; i > pos; i--) begin
      row_value[i] = row_value[i-1];
      row_prio[i]  = row_prio[i-1];
    end
    row_value[pos] = v;
    row_prio[pos]  = p;
    row_fill++;
  endfunction

  // close the slot at pos and report what left
  function automatic void remove_at(int unsigned pos, ref res_t r);
    r.removed_value    = row_value[pos];
    r.removed_priority = row_prio[pos];
    for (int unsigned i = pos; i + 1 < row_fill; i++) begin
      row_value[i] = row_value[i+1];
      row_prio[i]  = row_prio[i+1];
    end
    row_fill--;
  endfunction

  // apply one word to the shadow row and return the result it should give
  function automatic res_t apply_word(item_t w);
    res_t        r;
    int unsigned pos;
    r = '0;
    r.status = ST_OK;
    case (w.kind)
      KIND_PUSH_REAR, KIND_PUSH_FRONT, KIND_PRIO_INS: begin
        if (row_fill >= DEPTH_DEF) begin
          r.status = ST_FULL;
        end else if (w.kind == KIND_PUSH_REAR) begin
          insert_at(row_fill, w.value, w.priority_req);
        end else if (w.kind == KIND_PUSH_FRONT) begin
          insert_at(0, w.value, w.priority_req);
        end else begin
          // ahead of the first entry whose priority is not greater
          pos = 0;
          while (pos < row_fill && row_prio[pos] > w.priority_req) pos++;
          insert_at(pos, w.value, w.priority_req);
        end
      end
      KIND_POP_FRONT, KIND_POP_REAR, KIND_PRIO_DEL: begin
        if (row_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (w.kind == KIND_POP_FRONT) begin
          remove_at(0, r);
        end else if (w.kind == KIND_POP_REAR) begin
          remove_at(row_fill - 1, r);
        end else begin
          // front-most entry with an equal priority
          pos = 0;
          while (pos < row_fill && row_prio[pos] != w.priority_req) pos++;
          if (pos < row_fill) remove_at(pos, r);
          else r.status = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    if (row_fill != 0) begin
      r.front_value = row_value[0];
      r.rear_value  = row_value[row_fill-1];
    end
    r.entry_count = row_fill[COUNT_W-1:0];
    r.empty_flag  = (row_fill == 0);
    return r;
  endfunction

  function automatic void check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endfunction

  // watch both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_res;
    if (!rst_ni) begin
      row_fill = 0;
      result_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) result_q.push_back(apply_word(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result word with no word outstanding");
          errors++;
        end else begin
          exp_res = result_q.pop_front();
          check_field("status", exp_res.status, out_res_i.status);
          check_field("removed_value", exp_res.removed_value, out_res_i.removed_value);
          check_field("removed_priority", exp_res.removed_priority,
                      out_res_i.removed_priority);
          check_field("front_value", exp_res.front_value, out_res_i.front_value);
          check_field("rear_value", exp_res.rear_value, out_res_i.rear_value);
          check_field("entry_count", exp_res.entry_count, out_res_i.entry_count);
          check_field("empty_flag", exp_res.empty_flag, out_res_i.empty_flag);
        end
      end
    end
    err_cnt_o <= errors;
    pending_o <= result_q.size();
  end

endmodule

[tb/priority_deque_unit_tb.sv]
`timescale 1ns / 100ps

module priority_deque_unit_tb;
  import pdq_pkg::*;

  // the one kind code the block leaves unused, handled as a query
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int RANDOM_WORDS = 1700;
  localparam int CYCLE_LIMIT  = 1000000;

  logic  clk_i;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  item_t in_item_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  res_t  out_res_o;

  int err_cnt;
  int pending;
  int cycle_cnt = 0;
  int stall_hold = 0;
  int stall_roll;
  bit quiet_mode = 1'b0;

  priority_deque_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  priority_deque_checker checker_inst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_i  (out_res_o),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // hard stop on a hang
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side back-pressure: mostly short bursts, a few long ones
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (quiet_mode || stall_roll < 60) begin
        out_stall_i <= 1'b0;
        stall_hold  <= $urandom_range(0, 4);
      end else if (stall_roll < 92) begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(0, 3);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(8, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // priorities cluster on a few values so deletes find matches
  function automatic logic signed [PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return PRIO_W'($signed($urandom_range(0, 8)) - 4);
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return -16'sd1;
        default: return 16'sd0;
      endcase
    end
    return PRIO_W'($urandom);
  endfunction

  // grow favors pushes, otherwise removals dominate
  function automatic logic [KIND_W-1:0] pick_kind(bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return KIND_QUERY;
    if (r < 7) return KIND_UNUSED;
    r = $urandom_range(0, 99);
    if (grow ? (r < 68) : (r < 32)) begin
      case ($urandom_range(0, 2))
        0: return KIND_PUSH_REAR;
        1: return KIND_PUSH_FRONT;
        default: return KIND_PRIO_INS;
      endcase
    end
    case ($urandom_range(0, 2))
      0: return KIND_POP_FRONT;
      1: return KIND_POP_REAR;
      default: return KIND_PRIO_DEL;
    endcase
  endfunction

  // present one word and hold it until it is taken
  task automatic send_word(logic [KIND_W-1:0] kind, logic signed [VALUE_W-1:0] v,
                           logic signed [PRIO_W-1:0] p);
    int    gap;
    item_t w;
    gap = pick_gap();
    w.kind = kind;
    w.value = v;
    w.priority_req = p;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    bit grow;
    int phase_left;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // removals and queries on an empty row
    send_word(KIND_QUERY, 32'sd0, 16'sd0);
    send_word(KIND_UNUSED, 32'sd0, 16'sd0);
    send_word(KIND_POP_FRONT, 32'sd0, 16'sd0);
    send_word(KIND_POP_REAR, 32'sd0, 16'sd0);
    send_word(KIND_PRIO_DEL, 32'sd0, 16'sd0);
    // field extremes, ties on insert, missing key, equal-key delete
    send_word(KIND_PUSH_REAR, 32'sh7fffffff, 16'sh7fff);
    send_word(KIND_PUSH_FRONT, 32'sh80000000, 16'sh8000);
    send_word(KIND_PRIO_INS, 32'sd0, 16'sd0);
    send_word(KIND_PRIO_INS, -32'sd1, 16'sd0);
    send_word(KIND_PRIO_INS, 32'sd5, -16'sd1);
    send_word(KIND_PRIO_DEL, 32'sd0, 16'sd1234);
    send_word(KIND_PRIO_DEL, 32'sd0, 16'sd0);
    send_word(KIND_POP_FRONT, 32'sd0, 16'sd0);
    send_word(KIND_POP_REAR, 32'sd0, 16'sd0);
    // fill the row, then push into a full row three ways
    for (int i = 0; i < DEPTH_DEF; i++) begin
      send_word((i % 2) ? KIND_PRIO_INS : KIND_PUSH_REAR, VALUE_W'(i * 37 + 1),
                PRIO_W'(i % 3));
    end
    send_word(KIND_PUSH_REAR, 32'sd11, 16'sd0);
    send_word(KIND_PUSH_FRONT, 32'sd12, 16'sd0);
    send_word(KIND_PRIO_INS, 32'sd13, 16'sd0);

    // random words, alternating growing and shrinking phases
    grow = 1'b0;
    phase_left = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (phase_left == 0) begin
        grow = !grow;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      quiet_mode <= ((i / 150) % 4 == 3);
      send_word(pick_kind(grow), VALUE_W'($urandom), pick_prio());
    end
    in_valid_i <= 1'b0;
    quiet_mode <= 1'b0;

    // let the count of the last word settle, drain, then let any stray word show up
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/pdq_pkg.sv
sv/pdq_cell.sv
sv/priority_deque_unit.sv
tb/priority_deque_checker.sv
tb/priority_deque_unit_tb.sv
